// File: src/p2pm_pkg.sv
// shared constants and types of the perspective-to-perspective remap pipeline
// no dependencies
package p2pm_pkg;

    localparam int FIX_W   = 20;   // focal, center and output field width
    localparam int CFG_W   = 54;
    localparam int IDX_W   = 3;
    localparam int ROT_W   = 18;   // Q2.16 matrix entry
    localparam int NQ_W    = 24;   // normalized ray, Q4.20
    localparam int PROD_W  = ROT_W + NQ_W;
    localparam int R_W     = 28;   // rotated ray
    localparam int Q_BITS  = 21;   // projection quotient bits before saturation
    localparam int D_W     = 31;   // projection divisor, 16 * z
    localparam int PM_W    = 48;   // magnitude of focal times rotated coordinate
    localparam int BV_W    = 39;   // behind-camera value before center add
    localparam int V_W     = 41;

    localparam logic signed [NQ_W-1:0]  NQ_MAX  = 24'sh7FFFFF;
    localparam logic signed [NQ_W-1:0]  NQ_MIN  = -24'sh800000;
    localparam logic signed [FIX_W-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [FIX_W-1:0] OUT_MIN = -20'sh80000;

    typedef enum logic [IDX_W-1:0] {
        REG_ROT0    = 3'd0,
        REG_ROT1    = 3'd1,
        REG_ROT2    = 3'd2,
        REG_SRC_FOC = 3'd3,
        REG_SRC_CEN = 3'd4,
        REG_DST_FOC = 3'd5,
        REG_DST_CEN = 3'd6
    } t_reg_idx;

    typedef logic [CFG_W-1:0] t_rot_rows [3];

    localparam logic [CFG_W-1:0] ROT0_RST = 54'h10_0000_0000_0000 >> 0;
    localparam logic [CFG_W-1:0] ROT1_RST = 54'd17179869184;
    localparam logic [CFG_W-1:0] ROT2_RST = 54'd65536;
    localparam logic [39:0]      FOC_RST  = 40'd268435712;

endpackage

// File: src/p2pm_if.sv
// channel interfaces of the remap block: pixel input, result output, config writes
// depends on p2pm_pkg
interface p2pm_in_if #(parameter int COORD_BITS = 13);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    modport source (output valid, src_col, src_row, input ready);
    modport sink   (input valid, src_col, src_row, output ready);
endinterface

interface p2pm_out_if import p2pm_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [FIX_W-1:0] dst_x;
    logic signed [FIX_W-1:0] dst_y;
    logic                    behind_camera;
    logic                    saturated;
    modport source (output valid, dst_x, dst_y, behind_camera, saturated, input ready);
    modport sink   (input valid, dst_x, dst_y, behind_camera, saturated, output ready);
endinterface

interface p2pm_cfg_if import p2pm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/p2pm_norm.sv
// source camera normalization: ((pix*16 - c) << 24) / f, restoring divider one bit a stage
// depends on p2pm_pkg
module p2pm_norm import p2pm_pkg::*; #(
    parameter int COORD_BITS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [COORD_BITS-1:0]  i_col,
    input  logic [COORD_BITS-1:0]  i_row,
    input  logic [39:0]            i_focal,
    input  logic [39:0]            i_center,
    output logic                   o_valid,
    output logic signed [NQ_W-1:0] o_nx,
    output logic signed [NQ_W-1:0] o_ny,
    output logic                   o_sat
);
    localparam int NSTEP = NQ_W;

    logic [FIX_W-1:0] w_f [2];
    logic [FIX_W-1:0] w_c [2];
    logic [FIX_W-1:0] w_pix [2];

    logic             r_vld [0:NSTEP];
    logic [FIX_W-1:0] r_rem [2][0:NSTEP];
    logic [NQ_W-1:0]  r_q   [2][0:NSTEP];
    logic             r_neg [2][0:NSTEP];
    logic             r_ovf [2][0:NSTEP];
    logic             r_zf  [2][0:NSTEP];
    logic             r_nz  [2][0:NSTEP];

    logic [FIX_W-1:0] n_rem [2][1:NSTEP];
    logic [NQ_W-1:0]  n_q   [2][1:NSTEP];
    logic signed [FIX_W:0] n_num [2];
    logic [FIX_W:0]   n_mag [2];

    logic signed [NQ_W-1:0] n_n [2];
    logic                   n_sat;
    logic signed [NQ_W-1:0] r_n [2];
    logic                   r_sat;
    logic                   r_vout;

    assign w_f[0]   = i_focal[39:20];
    assign w_f[1]   = i_focal[19:0];
    assign w_c[0]   = i_center[39:20];
    assign w_c[1]   = i_center[19:0];
    assign w_pix[0] = FIX_W'({i_col, 4'b0});
    assign w_pix[1] = FIX_W'({i_row, 4'b0});

    always_comb begin
        logic [FIX_W:0] t;
        logic           ge;
        n_sat = 1'b0;
        for (int l = 0; l < 2; l++) begin
            n_num[l] = $signed({1'b0, w_pix[l]}) - $signed({1'b0, w_c[l]});
            n_mag[l] = n_num[l][FIX_W] ? (FIX_W+1)'(-n_num[l]) : n_num[l];
            for (int k = 1; k <= NSTEP; k++) begin
                t  = {r_rem[l][k-1], 1'b0};
                ge = (t >= {1'b0, w_f[l]});
                n_rem[l][k] = ge ? FIX_W'(t - {1'b0, w_f[l]}) : FIX_W'(t);
                n_q[l][k]   = {r_q[l][k-1][NQ_W-2:0], ge};
            end
            // final saturation of the quotient to Q4.20
            if (r_zf[l][NSTEP]) begin
                n_sat  = 1'b1;
                n_n[l] = !r_nz[l][NSTEP] ? '0 : (r_neg[l][NSTEP] ? NQ_MIN : NQ_MAX);
            end else if (r_ovf[l][NSTEP]) begin
                n_sat  = 1'b1;
                n_n[l] = r_neg[l][NSTEP] ? NQ_MIN : NQ_MAX;
            end else if (!r_neg[l][NSTEP]) begin
                if (r_q[l][NSTEP][NQ_W-1]) begin
                    n_sat  = 1'b1;
                    n_n[l] = NQ_MAX;
                end else begin
                    n_n[l] = $signed(r_q[l][NSTEP]);
                end
            end else begin
                if (r_q[l][NSTEP] > NQ_W'(24'h800000)) begin
                    n_sat  = 1'b1;
                    n_n[l] = NQ_MIN;
                end else begin
                    n_n[l] = -$signed(r_q[l][NSTEP]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTEP; k++) r_vld[k] <= 1'b0;
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NSTEP; k++) r_vld[k] <= r_vld[k-1];
            r_vout <= r_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= FIX_W'(n_mag[l]);
                r_q[l][0]   <= '0;
                r_neg[l][0] <= n_num[l][FIX_W];
                r_nz[l][0]  <= (n_num[l] != '0);
                r_zf[l][0]  <= (w_f[l] == '0);
                r_ovf[l][0] <= (n_mag[l] >= {1'b0, w_f[l]});
                for (int k = 1; k <= NSTEP; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_q[l][k]   <= n_q[l][k];
                    r_neg[l][k] <= r_neg[l][k-1];
                    r_nz[l][k]  <= r_nz[l][k-1];
                    r_zf[l][k]  <= r_zf[l][k-1];
                    r_ovf[l][k] <= r_ovf[l][k-1];
                end
                r_n[l] <= n_n[l];
            end
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_vout;
    assign o_nx    = r_n[0];
    assign o_ny    = r_n[1];
    assign o_sat   = r_sat;

endmodule

// File: src/p2pm_rot.sv
// 3x3 rotation of the normalized ray: products in one stage, rounding and sums in the next
// depends on p2pm_pkg
module p2pm_rot import p2pm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [NQ_W-1:0] i_nx,
    input  logic signed [NQ_W-1:0] i_ny,
    input  logic                   i_sat,
    input  t_rot_rows              i_rows,
    output logic                   o_valid,
    output logic signed [R_W-1:0]  o_r [3],
    output logic                   o_sat
);
    logic signed [ROT_W-1:0]  w_e [3][3];
    logic signed [PROD_W-1:0] r_p [3][3];
    logic signed [R_W-1:0]    r_r [3];
    logic signed [R_W-1:0]    n_r [3];
    logic [1:0]               r_vld;
    logic [1:0]               r_sat;

    always_comb begin
        logic signed [PROD_W-1:0] t;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) w_e[i][j] = $signed(i_rows[i][CFG_W-1-ROT_W*j -: ROT_W]);
            n_r[i] = '0;
            for (int j = 0; j < 3; j++) begin
                // halves round up: floor((p + 2^15) / 2^16)
                t = r_p[i][j] + PROD_W'(32768);
                n_r[i] = n_r[i] + R_W'(t >>> 16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i][0] <= PROD_W'(w_e[i][0] * i_nx);
                r_p[i][1] <= PROD_W'(w_e[i][1] * i_ny);
                // z of the normalized ray is exactly 1.0
                r_p[i][2] <= PROD_W'(w_e[i][2]) <<< 20;
                r_r[i]    <= n_r[i];
            end
            r_sat <= {r_sat[0], i_sat};
        end
    end

    assign o_valid = r_vld[1];
    assign o_r     = r_r;
    assign o_sat   = r_sat[1];

endmodule

// File: src/p2pm_proj.sv
// destination projection: (f * a) / (16 * z) + c per axis, restoring divider one bit a stage,
// with the behind-camera value and output clipping; depends on p2pm_pkg
module p2pm_proj import p2pm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [R_W-1:0]   i_r [3],
    input  logic                    i_sat,
    input  logic [39:0]             i_focal,
    input  logic [39:0]             i_center,
    output logic                    o_valid,
    output logic signed [FIX_W-1:0] o_x,
    output logic signed [FIX_W-1:0] o_y,
    output logic                    o_behind,
    output logic                    o_sat
);
    localparam int PSTEP = Q_BITS;

    logic [FIX_W-1:0] w_f [2];
    logic [FIX_W-1:0] w_c [2];

    // first stage: products
    logic                    r_v0;
    logic signed [PM_W:0]    r_prod [2];
    logic [39:0]             r_fc [2];
    logic [D_W-1:0]          r_d0;
    logic                    r_beh0;
    logic                    r_sat0;

    // divider stages
    logic                r_vld [0:PSTEP];
    logic [D_W-1:0]      r_d   [0:PSTEP];
    logic                r_beh [0:PSTEP];
    logic                r_sat [0:PSTEP];
    logic [D_W-1:0]      r_rem [2][0:PSTEP];
    logic [Q_BITS-1:0]   r_low [2][0:PSTEP];
    logic [Q_BITS-1:0]   r_q   [2][0:PSTEP];
    logic                r_neg [2][0:PSTEP];
    logic                r_ovf [2][0:PSTEP];
    logic [BV_W-1:0]     r_bv  [2][0:PSTEP];

    logic [D_W-1:0]      n_rem [2][1:PSTEP];
    logic [Q_BITS-1:0]   n_q   [2][1:PSTEP];
    logic [PM_W-1:0]     n_mag [2];
    logic [BV_W-1:0]     n_bv  [2];

    logic signed [FIX_W-1:0] n_o [2];
    logic                    n_sat;
    logic signed [FIX_W-1:0] r_o [2];
    logic                    r_osat;
    logic                    r_obeh;
    logic                    r_vout;

    assign w_f[0] = i_focal[39:20];
    assign w_f[1] = i_focal[19:0];
    assign w_c[0] = i_center[39:20];
    assign w_c[1] = i_center[19:0];

    always_comb begin
        logic [D_W:0]            t;
        logic                    ge;
        logic [46:0]             x100;
        logic [Q_BITS:0]         qm;
        logic signed [V_W-1:0]   v;
        n_sat = r_sat[PSTEP] || (w_f[0] == '0) || (w_f[1] == '0);
        for (int l = 0; l < 2; l++) begin
            n_mag[l] = r_prod[l][PM_W] ? PM_W'(-r_prod[l]) : PM_W'(r_prod[l]);
            x100     = (47'(r_fc[l]) << 6) + (47'(r_fc[l]) << 5) + (47'(r_fc[l]) << 2);
            n_bv[l]  = BV_W'(x100 >> 8);
            for (int k = 1; k <= PSTEP; k++) begin
                t  = {r_rem[l][k-1], r_low[l][k-1][Q_BITS-1]};
                ge = (t >= {1'b0, r_d[k-1]});
                n_rem[l][k] = ge ? D_W'(t - {1'b0, r_d[k-1]}) : D_W'(t);
                n_q[l][k]   = {r_q[l][k-1][Q_BITS-2:0], ge};
            end
            // an overflowing quotient clips whatever the center adds
            qm = r_ovf[l][PSTEP] ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, r_q[l][PSTEP]};
            if (r_beh[PSTEP]) begin
                v = $signed({2'b0, r_bv[l][PSTEP]}) + $signed({21'b0, w_c[l]});
            end else if (r_neg[l][PSTEP]) begin
                v = -$signed({19'b0, qm}) + $signed({21'b0, w_c[l]});
            end else begin
                v = $signed({19'b0, qm}) + $signed({21'b0, w_c[l]});
            end
            if (v > V_W'(OUT_MAX)) begin
                n_o[l] = OUT_MAX;
                n_sat  = 1'b1;
            end else if (v < V_W'(OUT_MIN)) begin
                n_o[l] = OUT_MIN;
                n_sat  = 1'b1;
            end else begin
                n_o[l] = FIX_W'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 0; k <= PSTEP; k++) r_vld[k] <= 1'b0;
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_v0     <= i_valid;
            r_vld[0] <= r_v0;
            for (int k = 1; k <= PSTEP; k++) r_vld[k] <= r_vld[k-1];
            r_vout <= r_vld[PSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= (PM_W+1)'($signed({1'b0, w_f[0]}) * i_r[0]);
            r_prod[1] <= (PM_W+1)'($signed({1'b0, w_f[1]}) * i_r[1]);
            r_fc[0]   <= w_f[0] * w_c[0];
            r_fc[1]   <= w_f[1] * w_c[1];
            r_d0      <= {i_r[2][D_W-5:0], 4'b0};
            r_beh0    <= i_r[2][R_W-1] || (i_r[2] == '0);
            r_sat0    <= i_sat;

            r_d[0]   <= r_d0;
            r_beh[0] <= r_beh0;
            r_sat[0] <= r_sat0;
            for (int k = 1; k <= PSTEP; k++) begin
                r_d[k]   <= r_d[k-1];
                r_beh[k] <= r_beh[k-1];
                r_sat[k] <= r_sat[k-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= D_W'(n_mag[l][PM_W-1:Q_BITS]);
                r_low[l][0] <= n_mag[l][Q_BITS-1:0];
                r_q[l][0]   <= '0;
                r_neg[l][0] <= r_prod[l][PM_W];
                r_ovf[l][0] <= ({4'b0, n_mag[l][PM_W-1:Q_BITS]} >= r_d0);
                r_bv[l][0]  <= n_bv[l];
                for (int k = 1; k <= PSTEP; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_low[l][k] <= {r_low[l][k-1][Q_BITS-2:0], 1'b0};
                    r_q[l][k]   <= n_q[l][k];
                    r_neg[l][k] <= r_neg[l][k-1];
                    r_ovf[l][k] <= r_ovf[l][k-1];
                    r_bv[l][k]  <= r_bv[l][k-1];
                end
                r_o[l] <= n_o[l];
            end
            r_osat <= n_sat;
            r_obeh <= r_beh[PSTEP];
        end
    end

    assign o_valid  = r_vout;
    assign o_x      = r_o[0];
    assign o_y      = r_o[1];
    assign o_behind = r_obeh;
    assign o_sat    = r_osat;

endmodule

// File: src/perspective_to_perspective_map_unit.sv
// an accepted item passes 52 register stages (26 normalize, 2 rotate, 24 project) before it
// shows as a valid result that can be taken
// throughput one item per cycle; the whole pipeline advances while the output register is
// empty or being taken, and holds as one when a finished result waits
// synchronous active-low reset clears every valid bit and restores the camera registers
// to identity rotation, unit focal lengths and zero centers
// depends on p2pm_pkg, p2pm_if, p2pm_norm, p2pm_rot, p2pm_proj
module perspective_to_perspective_map_unit import p2pm_pkg::*; #(
    parameter int COORD_BITS = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    p2pm_in_if.sink     i_pix,
    p2pm_cfg_if.sink    i_cfg,
    p2pm_out_if.source  o_res
);
    t_rot_rows   r_rot;
    logic [39:0] r_src_foc, r_src_cen, r_dst_foc, r_dst_cen;

    logic                   w_en;
    logic                   w_nv, w_nsat;
    logic signed [NQ_W-1:0] w_nx, w_ny;
    logic                   w_rv, w_rsat;
    logic signed [R_W-1:0]  w_r [3];
    logic                   w_ov;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]  <= ROT0_RST;
            r_rot[1]  <= ROT1_RST;
            r_rot[2]  <= ROT2_RST;
            r_src_foc <= FOC_RST;
            r_src_cen <= '0;
            r_dst_foc <= FOC_RST;
            r_dst_cen <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROT0:    r_rot[0]  <= i_cfg.data;
                REG_ROT1:    r_rot[1]  <= i_cfg.data;
                REG_ROT2:    r_rot[2]  <= i_cfg.data;
                REG_SRC_FOC: r_src_foc <= i_cfg.data[39:0];
                REG_SRC_CEN: r_src_cen <= i_cfg.data[39:0];
                REG_DST_FOC: r_dst_foc <= i_cfg.data[39:0];
                REG_DST_CEN: r_dst_cen <= i_cfg.data[39:0];
                default: ;
            endcase
        end
    end

    // the pipeline moves as one while the output register can take an item
    assign w_en        = !w_ov || o_res.ready;
    assign i_pix.ready = w_en;

    p2pm_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_pix.valid),
        .i_col    (i_pix.src_col),
        .i_row    (i_pix.src_row),
        .i_focal  (r_src_foc),
        .i_center (r_src_cen),
        .o_valid  (w_nv),
        .o_nx     (w_nx),
        .o_ny     (w_ny),
        .o_sat    (w_nsat)
    );

    p2pm_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_nv),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .i_sat   (w_nsat),
        .i_rows  (r_rot),
        .o_valid (w_rv),
        .o_r     (w_r),
        .o_sat   (w_rsat)
    );

    p2pm_proj u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_rv),
        .i_r      (w_r),
        .i_sat    (w_rsat),
        .i_focal  (r_dst_foc),
        .i_center (r_dst_cen),
        .o_valid  (w_ov),
        .o_x      (o_res.dst_x),
        .o_y      (o_res.dst_y),
        .o_behind (o_res.behind_camera),
        .o_sat    (o_res.saturated)
    );

    assign o_res.valid = w_ov;

endmodule

// File: src/p2pm_chk.sv
// port-level checks of the remap block, bound to the top level
// depends on p2pm_pkg and perspective_to_perspective_map_unit
module p2pm_chk import p2pm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_cfg_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [FIX_W-1:0] i_dst_x,
    input logic signed [FIX_W-1:0] i_dst_y
);
    // config writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("config channel not ready");

    // input side follows the output register: new items enter whenever it can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output register");

    // a waiting result keeps its coordinates
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_dst_x) && $stable(i_dst_y))
        else $error("stalled result changed");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind perspective_to_perspective_map_unit p2pm_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_dst_x     (o_res.dst_x),
    .i_dst_y     (o_res.dst_y)
);
